// ===== hw/rtl/i2c_eeprom_transfer_sequencer_top_assert.svh =====
// Assertion macros used by the checker file.
`ifndef I2C_EEPROM_TRANSFER_SEQUENCER_TOP_ASSERT_SVH
`define I2C_EEPROM_TRANSFER_SEQUENCER_TOP_ASSERT_SVH

// cond holds in the same cycle as trig
`define IETS_ASSERT(lbl, trig, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cond)) \
		else $error(msg);

// cond holds in the cycle after trig
`define IETS_ASSERT_NEXT(lbl, trig, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error(msg);

`endif

// ===== hw/rtl/iets_pkg.sv =====
package iets_pkg;

	typedef enum logic [2:0] {
		OP_START   = 3'd0,
		OP_STOP    = 3'd1,
		OP_SEND    = 3'd2,
		OP_RX_ACK  = 3'd3,
		OP_RX_NACK = 3'd4,
		OP_WAIT    = 3'd5,
		OP_NONE    = 3'd6
	} bus_op_t;

	typedef enum logic [1:0] {
		REG_DEV_SEL   = 2'd0,
		REG_SHORT     = 2'd1,
		REG_PAGE_LOG2 = 2'd2,
		REG_CAPACITY  = 2'd3
	} cfg_reg_t;

	localparam int NSLOT  = 19;
	localparam int SLOT_W = $clog2(NSLOT);

	typedef logic [SLOT_W-1:0] slot_idx_t;
	typedef logic [NSLOT-1:0]  slot_mask_t;

	// bus ops of one word, in emission order
	localparam slot_idx_t SL_PRE_STOP  = SLOT_W'(0);
	localparam slot_idx_t SL_PRE_WAIT  = SLOT_W'(1);
	localparam slot_idx_t SL_NONE      = SLOT_W'(2);
	localparam slot_idx_t SL_START1    = SLOT_W'(3);
	localparam slot_idx_t SL_DEV1      = SLOT_W'(4);
	localparam slot_idx_t SL_HI1       = SLOT_W'(5);
	localparam slot_idx_t SL_LO1       = SLOT_W'(6);
	localparam slot_idx_t SL_RSTART    = SLOT_W'(7);
	localparam slot_idx_t SL_RSEL      = SLOT_W'(8);
	localparam slot_idx_t SL_RX_ACK    = SLOT_W'(9);
	localparam slot_idx_t SL_RX_NACK   = SLOT_W'(10);
	localparam slot_idx_t SL_RX_STOP   = SLOT_W'(11);
	localparam slot_idx_t SL_DATA      = SLOT_W'(12);
	localparam slot_idx_t SL_POST_STOP = SLOT_W'(13);
	localparam slot_idx_t SL_POST_WAIT = SLOT_W'(14);
	localparam slot_idx_t SL_START2    = SLOT_W'(15);
	localparam slot_idx_t SL_DEV2      = SLOT_W'(16);
	localparam slot_idx_t SL_HI2       = SLOT_W'(17);
	localparam slot_idx_t SL_LO2       = SLOT_W'(18);

	typedef struct packed {
		slot_mask_t  mask;
		logic [7:0]  wr_byte;
		logic        rej;
	} desc_t;

	localparam int DESC_W = $bits(desc_t);

	typedef struct packed {
		logic [7:0]  dev_sel;
		logic        short_mode;
		logic [3:0]  page_log2;
		logic [16:0] capacity;
	} cfg_t;

endpackage

// ===== hw/rtl/i2c_eeprom_transfer_sequencer_top.sv =====
// Byte-level EEPROM transfer to I2C bus operation sequencer. A front stage takes one
// input word per cycle while its two-entry queue has room, checks the transfer range,
// tracks the open transfer and plans the bus operations of the word; a back stage
// emits them one per cycle, while the output is not stalled, into an output register,
// with run_end on the last one. A word produces 1 to 13 bus operations; the back
// sequencer's one-operation-per-cycle output sets the sustained rate. The bus side
// waits on out_ready without stalling input until the queue fills. Configuration
// is read live by both stages, so write it only while the block is idle.
module i2c_eeprom_transfer_sequencer_top import iets_pkg::*; #(
	parameter int ADDR_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [16:0] cfg_wr_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        kind,
	input  logic        first_of_transfer,
	input  logic        last_of_transfer,
	input  logic [15:0] start_address,
	input  logic [15:0] byte_count,
	input  logic [7:0]  write_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  bus_op,
	output logic [7:0]  bus_byte,
	output logic        rejected,
	output logic        run_end
);

	localparam int QW = DESC_W + ADDR_BITS;

	cfg_t                 cfg_q;
	logic                 push_valid, push_ready, pop_valid, pop;
	desc_t                push_desc, pop_desc;
	logic [ADDR_BITS-1:0] push_addr, pop_addr;
	logic [QW-1:0]        pop_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dev_sel    <= 8'd160;
			cfg_q.short_mode <= 1'b0;
			cfg_q.page_log2  <= 4'd6;
			cfg_q.capacity   <= 17'd32768;
		end else if (cfg_wr_en) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_DEV_SEL:   cfg_q.dev_sel    <= cfg_wr_data[7:0];
				REG_SHORT:     cfg_q.short_mode <= cfg_wr_data[0];
				REG_PAGE_LOG2: cfg_q.page_log2  <= cfg_wr_data[3:0];
				REG_CAPACITY:  cfg_q.capacity   <= cfg_wr_data;
				default:       cfg_q.capacity   <= cfg_q.capacity;
			endcase
		end
	end

	iets_front #(.ADDR_BITS(ADDR_BITS)) u_front (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.kind              (kind),
		.first_of_transfer (first_of_transfer),
		.last_of_transfer  (last_of_transfer),
		.start_address     (start_address),
		.byte_count        (byte_count),
		.write_byte        (write_byte),
		.cfg               (cfg_q),
		.push_valid        (push_valid),
		.push_ready        (push_ready),
		.push_desc         (push_desc),
		.push_addr         (push_addr)
	);

	iets_fifo #(.W(QW)) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  ({push_addr, push_desc}),
		.pop_valid  (pop_valid),
		.pop        (pop),
		.pop_data   (pop_data)
	);

	assign pop_desc = desc_t'(pop_data[DESC_W-1:0]);
	assign pop_addr = pop_data[QW-1:DESC_W];

	iets_back #(.ADDR_BITS(ADDR_BITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.pop_valid (pop_valid),
		.pop       (pop),
		.pop_desc  (pop_desc),
		.pop_addr  (pop_addr),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.bus_op    (bus_op),
		.bus_byte  (bus_byte),
		.rejected  (rejected),
		.run_end   (run_end)
	);

endmodule

// ===== hw/rtl/iets_front.sv =====
module iets_front import iets_pkg::*; #(
	parameter int ADDR_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 kind,
	input  logic                 first_of_transfer,
	input  logic                 last_of_transfer,
	input  logic [15:0]          start_address,
	input  logic [15:0]          byte_count,
	input  logic [7:0]           write_byte,
	input  cfg_t                 cfg,
	output logic                 push_valid,
	input  logic                 push_ready,
	output desc_t                push_desc,
	output logic [ADDR_BITS-1:0] push_addr
);

	logic                 active_q, refused_q, kind_q;
	logic [ADDR_BITS-1:0] next_q;

	logic                 active_n, refused_n, kind_n;
	logic                 refuse, body_on, boundary, accept;
	logic [16:0]          end_addr;
	logic [ADDR_BITS-1:0] body_addr, inc_addr;
	logic [3:0]           plog;
	logic [7:0]           pmask;
	slot_mask_t           mask;
	logic                 rej;

	assign accept     = in_valid && push_ready;
	assign in_ready   = push_ready;
	assign push_valid = in_valid;

	assign end_addr = {1'b0, start_address} + {1'b0, byte_count};
	assign refuse   = (byte_count == 16'd0) || (end_addr > cfg.capacity);
	assign plog     = (cfg.page_log2 > 4'd8) ? 4'd8 : cfg.page_log2;
	assign pmask    = 8'((9'd1 << plog) - 9'd1);

	always_comb begin
		mask      = '0;
		rej       = 1'b0;
		active_n  = active_q;
		refused_n = refused_q;
		kind_n    = kind_q;
		body_addr = next_q;
		body_on   = first_of_transfer ? !refuse : active_q;
		if (first_of_transfer) begin
			// close an open transfer before the new one
			if (active_q) begin
				mask[SL_PRE_STOP] = 1'b1;
				mask[SL_PRE_WAIT] = !kind_q;
			end
			active_n  = 1'b0;
			refused_n = 1'b0;
			kind_n    = kind;
			if (refuse) begin
				mask[SL_NONE] = 1'b1;
				rej           = 1'b1;
				refused_n     = !last_of_transfer;
			end else begin
				active_n          = 1'b1;
				body_addr         = start_address[ADDR_BITS-1:0];
				mask[SL_START1]   = 1'b1;
				mask[SL_DEV1]     = 1'b1;
				mask[SL_HI1]      = !cfg.short_mode;
				mask[SL_LO1]      = 1'b1;
				mask[SL_RSTART]   = kind;
				mask[SL_RSEL]     = kind;
			end
		end else if (refused_q) begin
			mask[SL_NONE] = 1'b1;
			rej           = 1'b1;
			if (last_of_transfer) refused_n = 1'b0;
		end else if (!active_q) begin
			mask[SL_NONE] = 1'b1;
		end

		inc_addr = body_addr + ADDR_BITS'(1);
		boundary = (inc_addr[7:0] & pmask) == 8'd0;

		if (body_on) begin
			if (kind_n) begin
				mask[SL_RX_ACK]  = !last_of_transfer;
				mask[SL_RX_NACK] = last_of_transfer;
				mask[SL_RX_STOP] = last_of_transfer;
			end else begin
				mask[SL_DATA]      = 1'b1;
				mask[SL_POST_STOP] = boundary || last_of_transfer;
				mask[SL_POST_WAIT] = boundary || last_of_transfer;
				// next page is re-addressed only if the transfer goes on
				mask[SL_START2]    = boundary && !last_of_transfer;
				mask[SL_DEV2]      = boundary && !last_of_transfer;
				mask[SL_HI2]       = boundary && !last_of_transfer && !cfg.short_mode;
				mask[SL_LO2]       = boundary && !last_of_transfer;
			end
			if (last_of_transfer) active_n = 1'b0;
		end
	end

	assign push_desc.mask    = mask;
	assign push_desc.wr_byte = write_byte;
	assign push_desc.rej     = rej;
	assign push_addr         = body_addr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= 1'b0;
			refused_q <= 1'b0;
			kind_q    <= 1'b0;
			next_q    <= '0;
		end else if (accept) begin
			active_q  <= active_n;
			refused_q <= refused_n;
			kind_q    <= kind_n;
			if (body_on) next_q <= inc_addr;
		end
	end

endmodule

// ===== hw/rtl/iets_fifo.sv =====
module iets_fifo #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push_valid,
	output logic         push_ready,
	input  logic [W-1:0] push_data,
	output logic         pop_valid,
	input  logic         pop,
	output logic [W-1:0] pop_data
);

	localparam int DEPTH = 2;

	logic [W-1:0] mem_q [DEPTH];
	logic         wr_ptr_q, rd_ptr_q;
	logic [1:0]   count_q;
	logic         do_push, do_pop;

	assign push_ready = count_q != 2'(DEPTH);
	assign pop_valid  = count_q != 2'd0;
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= !wr_ptr_q;
			if (do_pop) rd_ptr_q <= !rd_ptr_q;
			count_q <= count_q + 2'(do_push) - 2'(do_pop);
		end
	end

endmodule

// ===== hw/rtl/iets_back.sv =====
module iets_back import iets_pkg::*; #(
	parameter int ADDR_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cfg_t                 cfg,
	input  logic                 pop_valid,
	output logic                 pop,
	input  desc_t                pop_desc,
	input  logic [ADDR_BITS-1:0] pop_addr,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [2:0]           bus_op,
	output logic [7:0]           bus_byte,
	output logic                 rejected,
	output logic                 run_end
);

	slot_mask_t           cur_q;
	logic [7:0]           wb_q;
	logic                 rej_q;
	logic [ADDR_BITS-1:0] addr_q;

	logic                 valid_q, rej_out_q, end_q;
	bus_op_t              op_q;
	logic [7:0]           byte_q;

	slot_mask_t rest;
	slot_idx_t  idx;
	logic       adv, busy;
	bus_op_t    op;
	logic [7:0] bval;
	logic [15:0] ext1, ext2;

	assign adv  = !valid_q || out_ready;
	assign busy = cur_q != '0;
	assign rest = cur_q & (cur_q - NSLOT'(1));
	assign pop  = pop_valid && (!busy || (adv && rest == '0));
	assign ext1 = 16'(addr_q);
	assign ext2 = 16'(addr_q + ADDR_BITS'(1));

	always_comb begin
		idx = '0;
		for (int i = NSLOT - 1; i >= 0; i--) begin
			if (cur_q[i]) idx = SLOT_W'(i);
		end
	end

	always_comb begin
		op   = OP_NONE;
		bval = 8'd0;
		unique case (idx)
			SL_PRE_STOP, SL_RX_STOP, SL_POST_STOP: op = OP_STOP;
			SL_PRE_WAIT, SL_POST_WAIT:             op = OP_WAIT;
			SL_START1, SL_RSTART, SL_START2:       op = OP_START;
			SL_RX_ACK:                             op = OP_RX_ACK;
			SL_RX_NACK:                            op = OP_RX_NACK;
			SL_DEV1, SL_DEV2: begin
				op   = OP_SEND;
				bval = cfg.dev_sel;
			end
			SL_RSEL: begin
				op   = OP_SEND;
				bval = cfg.dev_sel + 8'd1;
			end
			SL_HI1: begin
				op   = OP_SEND;
				bval = ext1[15:8];
			end
			SL_LO1: begin
				op   = OP_SEND;
				bval = ext1[7:0];
			end
			SL_HI2: begin
				op   = OP_SEND;
				bval = ext2[15:8];
			end
			SL_LO2: begin
				op   = OP_SEND;
				bval = ext2[7:0];
			end
			SL_DATA: begin
				op   = OP_SEND;
				bval = wb_q;
			end
			default: op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			wb_q   <= pop_desc.wr_byte;
			rej_q  <= pop_desc.rej;
			addr_q <= pop_addr;
		end
		if (adv && busy) begin
			op_q      <= op;
			byte_q    <= bval;
			rej_out_q <= rej_q && (idx == SL_NONE);
			end_q     <= rest == '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (pop) cur_q <= pop_desc.mask;
			else if (adv) cur_q <= rest;
			if (adv) valid_q <= busy;
		end
	end

	assign out_valid = valid_q;
	assign bus_op    = op_q;
	assign bus_byte  = byte_q;
	assign rejected  = rej_out_q;
	assign run_end   = end_q;

endmodule

// ===== hw/rtl/iets_checker.sv =====
`include "i2c_eeprom_transfer_sequencer_top_assert.svh"

module iets_checker import iets_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [2:0] bus_op,
	input logic [7:0] bus_byte,
	input logic       rejected,
	input logic       run_end
);

	`IETS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(bus_op) && $stable(bus_byte) && $stable(run_end), "stalled output word changed")
	`IETS_ASSERT(a_rej_none, out_valid && rejected, bus_op == OP_NONE, "rejected set on a bus operation")
	`IETS_ASSERT(a_none_ends, out_valid && bus_op == OP_NONE, run_end, "none is not the last word of its item")
	`IETS_ASSERT(a_byte_zero, out_valid && bus_op != OP_SEND, bus_byte == 8'd0, "byte nonzero outside send")

endmodule

bind i2c_eeprom_transfer_sequencer_top iets_checker u_iets_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.bus_op    (bus_op),
	.bus_byte  (bus_byte),
	.rejected  (rejected),
	.run_end   (run_end)
);

// ===== test/bus_op_checker.sv =====
`timescale 1ns / 100ps

module bus_op_checker import iets_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [16:0] cfg_wr_data,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic        kind,
	input  logic        first_of_transfer,
	input  logic        last_of_transfer,
	input  logic [15:0] start_address,
	input  logic [15:0] byte_count,
	input  logic [7:0]  write_byte,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [2:0]  bus_op,
	input  logic [7:0]  bus_byte,
	input  logic        rejected,
	input  logic        run_end,
	output int          pending_count,
	output int          fail_count
);

	typedef struct packed {
		bus_op_t    op;
		logic [7:0] data;
		logic       rej;
		logic       done;
	} bus_step_t;

	bus_step_t ops_due[$];
	bus_step_t got_step;
	bus_step_t want_step;
	int        mismatches;

	// register copies
	logic [7:0]  dev_sel;
	logic        short_mode;
	logic [3:0]  page_log2;
	logic [16:0] capacity;

	// open transfer
	logic [15:0] nxt_addr;
	logic        xfer_open;
	logic        xfer_refused;
	logic        xfer_kind;

	function automatic void queue_op(input bus_op_t op, input logic [7:0] b, input logic rej);
		bus_step_t s;
		s.op   = op;
		s.data = b;
		s.rej  = rej;
		s.done = 1'b0;
		ops_due.push_back(s);
	endfunction

	function automatic void queue_address();
		queue_op(OP_START, 8'h00, 1'b0);
		queue_op(OP_SEND, dev_sel, 1'b0);
		if (!short_mode)
			queue_op(OP_SEND, nxt_addr[15:8], 1'b0);
		queue_op(OP_SEND, nxt_addr[7:0], 1'b0);
	endfunction

	function automatic void plan_word(input logic k, input logic f, input logic l,
		input logic [15:0] sa, input logic [15:0] cnt, input logic [7:0] wb);
		logic [3:0]  plog;
		logic [15:0] pmask;
		logic [16:0] span;
		plog  = (page_log2 > 4'd8) ? 4'd8 : page_log2;
		pmask = (16'd1 << plog) - 16'd1;
		span  = {1'b0, sa} + {1'b0, cnt};
		if (f) begin
			// a new first word closes whatever is open
			if (xfer_open) begin
				queue_op(OP_STOP, 8'h00, 1'b0);
				if (!xfer_kind)
					queue_op(OP_WAIT, 8'h00, 1'b0);
			end
			xfer_open    = 1'b0;
			xfer_refused = 1'b0;
			xfer_kind    = k;
			if (cnt == 16'd0 || span > capacity) begin
				queue_op(OP_NONE, 8'h00, 1'b1);
				xfer_refused = !l;
			end else begin
				xfer_open = 1'b1;
				nxt_addr  = sa;
				queue_address();
				if (k) begin
					queue_op(OP_START, 8'h00, 1'b0);
					queue_op(OP_SEND, dev_sel + 8'd1, 1'b0);
				end
			end
		end else if (xfer_refused) begin
			queue_op(OP_NONE, 8'h00, 1'b1);
			if (l)
				xfer_refused = 1'b0;
		end else if (!xfer_open) begin
			queue_op(OP_NONE, 8'h00, 1'b0);
		end

		if (xfer_open) begin
			if (xfer_kind) begin
				if (l) begin
					queue_op(OP_RX_NACK, 8'h00, 1'b0);
					queue_op(OP_STOP, 8'h00, 1'b0);
				end else begin
					queue_op(OP_RX_ACK, 8'h00, 1'b0);
				end
				nxt_addr = nxt_addr + 16'd1;
			end else begin
				queue_op(OP_SEND, wb, 1'b0);
				nxt_addr = nxt_addr + 16'd1;
				if ((nxt_addr & pmask) == 16'd0) begin
					queue_op(OP_STOP, 8'h00, 1'b0);
					queue_op(OP_WAIT, 8'h00, 1'b0);
					if (!l)
						queue_address();
				end else if (l) begin
					queue_op(OP_STOP, 8'h00, 1'b0);
					queue_op(OP_WAIT, 8'h00, 1'b0);
				end
			end
			if (l)
				xfer_open = 1'b0;
		end
		ops_due[ops_due.size() - 1].done = 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_sel       = 8'd160;
			short_mode    = 1'b0;
			page_log2     = 4'd6;
			capacity      = 17'd32768;
			nxt_addr      = 16'd0;
			xfer_open     = 1'b0;
			xfer_refused  = 1'b0;
			xfer_kind     = 1'b0;
			mismatches    = 0;
			ops_due.delete();
			pending_count <= 0;
			fail_count    <= 0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_reg_t'(cfg_index))
					REG_DEV_SEL:   dev_sel    = cfg_wr_data[7:0];
					REG_SHORT:     short_mode = cfg_wr_data[0];
					REG_PAGE_LOG2: page_log2  = cfg_wr_data[3:0];
					REG_CAPACITY:  capacity   = cfg_wr_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				plan_word(kind, first_of_transfer, last_of_transfer, start_address,
					byte_count, write_byte);
			if (out_valid && out_ready) begin
				got_step.op   = bus_op_t'(bus_op);
				got_step.data = bus_byte;
				got_step.rej  = rejected;
				got_step.done = run_end;
				if (ops_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected bus op: op=%0d byte=%02h rej=%b end=%b",
							bus_op, bus_byte, rejected, run_end);
				end else begin
					want_step = ops_due.pop_front();
					if (got_step !== want_step) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"bus op mismatch: expected op=%0d byte=%02h rej=%b end=%b,",
								" got op=%0d byte=%02h rej=%b end=%b"},
								want_step.op, want_step.data, want_step.rej, want_step.done,
								bus_op, bus_byte, rejected, run_end);
					end
				end
			end
			pending_count <= ops_due.size();
			fail_count    <= mismatches;
		end
	end

endmodule

// ===== test/i2c_eeprom_transfer_sequencer_top_test.sv =====
`timescale 1ns / 100ps

module i2c_eeprom_transfer_sequencer_top_test;
	import iets_pkg::*;

	localparam int STUCK_LIMIT = 3000;
	localparam int DRAIN_LIMIT = 3000;

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [1:0]  cfg_index;
	logic [16:0] cfg_wr_data;
	logic        in_valid;
	logic        in_ready;
	logic        kind;
	logic        first_of_transfer;
	logic        last_of_transfer;
	logic [15:0] start_address;
	logic [15:0] byte_count;
	logic [7:0]  write_byte;
	logic        out_valid;
	logic        out_ready;
	logic [2:0]  bus_op;
	logic [7:0]  bus_byte;
	logic        rejected;
	logic        run_end;

	int pending_count;
	int fail_count;
	int words_sent;
	int cur_plog;
	int cur_cap;
	bit quiet_run;

	i2c_eeprom_transfer_sequencer_top u_top (.*);

	bus_op_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic idle_gap();
		int r;
		int n;
		r = $urandom_range(0, 99);
		n = 0;
		if (!quiet_run) begin
			if (r >= 92)
				n = $urandom_range(8, 40);
			else if (r >= 55)
				n = $urandom_range(1, 3);
		end
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic send_word(input logic k, input logic f, input logic l,
		input logic [15:0] sa, input logic [15:0] cnt, input logic [7:0] wb);
		in_valid          <= 1'b1;
		kind              <= k;
		first_of_transfer <= f;
		last_of_transfer  <= l;
		start_address     <= sa;
		byte_count        <= cnt;
		write_byte        <= wb;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		words_sent++;
		idle_gap();
	endtask

	// wait until every bus op has come out or the drain limit is reached, then idle as a margin
	task automatic drain();
		int waited;
		waited = 0;
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (8) @(posedge clk);
	endtask

	task automatic set_config(input logic [7:0] dev, input logic short_sel,
		input logic [3:0] plog, input logic [16:0] cap);
		cfg_wr_en   <= 1'b1;
		cfg_index   <= REG_DEV_SEL;
		cfg_wr_data <= {9'd0, dev};
		@(posedge clk);
		cfg_index   <= REG_SHORT;
		cfg_wr_data <= {16'd0, short_sel};
		@(posedge clk);
		cfg_index   <= REG_PAGE_LOG2;
		cfg_wr_data <= {13'd0, plog};
		@(posedge clk);
		cfg_index   <= REG_CAPACITY;
		cfg_wr_data <= cap;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		@(posedge clk);
		cur_plog = (plog > 4'd8) ? 8 : int'(plog);
		cur_cap  = int'(cap);
	endtask

	task automatic send_transfer();
		int  r;
		int  len;
		int  sa;
		int  cnt;
		int  hi;
		int  pmask;
		bit  broken;
		logic k;
		r       = $urandom_range(0, 99);
		k       = 1'($urandom_range(0, 1));
		len     = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
		pmask   = (1 << cur_plog) - 1;
		broken  = 1'b0;
		quiet_run = ($urandom_range(0, 3) == 0);
		cnt     = len;
		if ($urandom_range(0, 5) == 0)
			cnt = len + $urandom_range(0, 300);
		case ($urandom_range(0, 9))
			0:       sa = 16'hFFFF - $urandom_range(0, 3);
			1, 2, 3: sa = ((($urandom & 16'hFFFF) | pmask) - $urandom_range(0, 2)) & 16'hFFFF;
			default: sa = $urandom & 16'hFFFF;
		endcase
		if (sa + cnt > cur_cap && cur_cap >= cnt) begin
			hi = cur_cap - cnt;
			if (hi > 65535)
				hi = 65535;
			sa = $urandom_range(0, hi);
		end
		if (r < 8) begin
			// stray word outside any transfer, or fully random noise
			send_word(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)), 16'($urandom), 16'($urandom), 8'($urandom));
		end else begin
			if (r < 12)
				cnt = 0;
			else if (r < 16)
				cnt = $urandom & 16'hFFFF;
			else if (r < 22)
				broken = 1'b1;
			for (int i = 0; i < len; i++) begin
				if (i == 0)
					send_word(k, 1'b1, (len == 1) && !broken, 16'(sa), 16'(cnt),
						8'($urandom));
				else
					send_word(1'($urandom_range(0, 1)), 1'b0, (i == len - 1) && !broken,
						16'($urandom), 16'($urandom), 8'($urandom));
			end
		end
	endtask

	initial begin : watchdog
		int stuck;
		stuck = 0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		while (stuck < STUCK_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				stuck = 0;
			else
				stuck++;
		end
		$display("TB_ERROR");
		$finish;
	end

	initial begin : bus_side
		int r;
		int n;
		out_ready <= 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		// long hold-off so the block backs up onto its input
		repeat (300) @(posedge clk);
		forever begin
			r = $urandom_range(0, 99);
			if (r < 60) begin
				out_ready <= 1'b1;
				n = $urandom_range(1, 24);
			end else if (r < 96) begin
				out_ready <= 1'b0;
				n = $urandom_range(1, 3);
			end else begin
				out_ready <= 1'b0;
				n = $urandom_range(10, 40);
			end
			repeat (n) @(posedge clk);
		end
	end

	initial begin
		int target;
		arst_n            <= 1'b0;
		cfg_wr_en         <= 1'b0;
		cfg_index         <= REG_DEV_SEL;
		cfg_wr_data       <= 17'd0;
		in_valid          <= 1'b0;
		kind              <= 1'b0;
		first_of_transfer <= 1'b0;
		last_of_transfer  <= 1'b0;
		start_address     <= 16'd0;
		byte_count        <= 16'd0;
		write_byte        <= 8'd0;
		words_sent        = 0;
		cur_plog          = 6;
		cur_cap           = 32768;
		quiet_run         = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed words at reset settings
		send_word(1'b0, 1'b0, 1'b0, 16'h0000, 16'h0000, 8'h00);   // stray
		send_word(1'b0, 1'b1, 1'b0, 16'h003E, 16'd3, 8'h00);      // write across page
		send_word(1'b1, 1'b0, 1'b0, 16'hFFFF, 16'hFFFF, 8'hFF);
		send_word(1'b0, 1'b0, 1'b1, 16'h0000, 16'h0000, 8'hA5);
		send_word(1'b0, 1'b1, 1'b1, 16'h007F, 16'd1, 8'h3C);      // ends on page boundary
		send_word(1'b1, 1'b1, 1'b0, 16'h1234, 16'd3, 8'h00);      // read
		send_word(1'b0, 1'b0, 1'b0, 16'h0000, 16'h0000, 8'h11);
		send_word(1'b0, 1'b0, 1'b1, 16'h0000, 16'h0000, 8'h22);
		send_word(1'b1, 1'b1, 1'b1, 16'h7FFF, 16'd1, 8'hFF);      // exact fit
		send_word(1'b0, 1'b1, 1'b0, 16'h0100, 16'd0, 8'h01);      // zero count
		send_word(1'b0, 1'b0, 1'b0, 16'h0000, 16'h0000, 8'h02);
		send_word(1'b1, 1'b0, 1'b1, 16'h0000, 16'h0000, 8'h03);
		send_word(1'b0, 1'b0, 1'b1, 16'h0000, 16'h0000, 8'h00);   // stray after end
		send_word(1'b1, 1'b1, 1'b1, 16'h7FFF, 16'd2, 8'h00);      // one past capacity
		send_word(1'b1, 1'b1, 1'b1, 16'hFFFF, 16'hFFFF, 8'hFF);
		send_word(1'b0, 1'b1, 1'b0, 16'h0010, 16'd5, 8'h77);      // write cut by new first
		send_word(1'b1, 1'b1, 1'b1, 16'h0020, 16'd1, 8'h00);
		send_word(1'b1, 1'b1, 1'b0, 16'h0200, 16'd4, 8'h00);      // read cut by new first
		send_word(1'b0, 1'b1, 1'b0, 16'h0300, 16'd2, 8'h80);
		send_word(1'b1, 1'b0, 1'b1, 16'h0000, 16'h0000, 8'h7F);
		send_word(1'b0, 1'b1, 1'b0, 16'h7000, 16'h2000, 8'h00);   // refused, then new first
		send_word(1'b0, 1'b1, 1'b1, 16'h0040, 16'd1, 8'h55);

		for (int phase = 1; phase <= 7; phase++) begin
			drain();
			case (phase)
				1: set_config(8'hA0, 1'b1, 4'd0, 17'd65536);
				2: set_config(8'hFF, 1'b0, 4'd8, 17'h1FFFF);
				3: set_config(8'h00, 1'b1, 4'd15, 17'd256);
				4: set_config(8'($urandom), 1'b0, 4'd3, 17'd0);
				5, 6: set_config(8'($urandom), 1'($urandom_range(0, 1)),
					4'($urandom_range(0, 15)), 17'($urandom_range(1, 131071)));
				default: set_config(8'hFE, 1'b0, 4'd2, 17'd1);
			endcase
			target = words_sent + ((phase == 4) ? 12 : 27);
			while (words_sent < target) send_transfer();
		end
		drain();

		if (fail_count == 0 && pending_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== i2c_eeprom_transfer_sequencer_top.f =====
+incdir+hw/rtl
hw/rtl/iets_pkg.sv
hw/rtl/iets_front.sv
hw/rtl/iets_fifo.sv
hw/rtl/iets_back.sv
hw/rtl/i2c_eeprom_transfer_sequencer_top.sv
hw/rtl/iets_checker.sv
test/bus_op_checker.sv
test/i2c_eeprom_transfer_sequencer_top_test.sv
